// ===== rtl/rbe_pkg.sv =====
// shared types, constants and helper functions for the rigid body integrator
// no dependencies; used by the top level and the testbench
package rbe_pkg;

  localparam int MaxVertices = 16;
  localparam int FracBits    = 16;
  localparam int VIdxW       = $clog2(MaxVertices);

  // request op codes
  localparam logic [2:0] OP_ADD_FORCE  = 3'd0;
  localparam logic [2:0] OP_ADD_TORQUE = 3'd1;
  localparam logic [2:0] OP_INTEGRATE  = 3'd2;
  localparam logic [2:0] OP_LOAD_VERT  = 3'd3;
  localparam logic [2:0] OP_PLACE      = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_INV_MASS     = 3'd0;
  localparam logic [2:0] REG_INV_INERTIA  = 3'd1;
  localparam logic [2:0] REG_TIME_STEP    = 3'd2;
  localparam logic [2:0] REG_IS_POLYGON   = 3'd3;
  localparam logic [2:0] REG_VERTEX_COUNT = 3'd4;

  localparam logic [15:0] TimeStepReset = 16'd1092;

  // angle constants in Q2.30
  localparam int CordicSteps = 30;
  localparam logic signed [46:0] PiQ30     = 47'sd3373259426;
  localparam logic signed [46:0] TwoPiQ30  = 47'sd6746518852;
  localparam logic signed [46:0] HalfPiQ30 = 47'sd1686629713;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  // floor(2^63 / 2pi_q30): quotient estimate for the angle reduction
  localparam logic [31:0] ModRecip =
    32'(64'h8000_0000_0000_0000 / 64'd6746518852);

  // arctangent of 2^-i in Q2.30
  function automatic logic signed [34:0] atan_q30(input logic [4:0] i);
    logic signed [34:0] a;
    case (i)
      5'd0:  a = 35'sd843314856;
      5'd1:  a = 35'sd497837829;
      5'd2:  a = 35'sd263043836;
      5'd3:  a = 35'sd133525158;
      5'd4:  a = 35'sd67021686;
      5'd5:  a = 35'sd33543515;
      5'd6:  a = 35'sd16775850;
      5'd7:  a = 35'sd8388437;
      5'd8:  a = 35'sd4194282;
      5'd9:  a = 35'sd2097149;
      default: a = 35'sd1 <<< (5'd30 - i);
    endcase
    return (i > 5'd29) ? 35'sd0 : a;
  endfunction

  // clamp a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647)       r = 32'sh7fffffff;
    else if (v < -68'sd2147483648) r = 32'sh80000000;
    else                           r = v[31:0];
    return r;
  endfunction

endpackage

// ===== rtl/rbe_in_if.sv =====
// request channel of the rigid body integrator: valid, ready and op payload
// depends on nothing
interface rbe_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic signed [31:0] value_x;
  logic signed [31:0] value_y;
  logic [3:0]         vertex_index;

  modport source (output valid, op, value_x, value_y, vertex_index, input ready);
  modport sink   (input valid, op, value_x, value_y, vertex_index, output ready);
endinterface

// ===== rtl/rbe_out_if.sv =====
// result channel of the rigid body integrator: valid, ready and world point
// depends on nothing
interface rbe_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         item_index;
  logic signed [31:0] world_x;
  logic signed [31:0] world_y;
  logic signed [31:0] body_angle;
  logic               last;

  modport source (output valid, item_index, world_x, world_y, body_angle, last,
                  input ready);
  modport sink   (input valid, item_index, world_x, world_y, body_angle, last,
                  output ready);
endinterface

// ===== rtl/rigid_body_euler_integrator.sv =====
// 2D rigid body integrator: a sequencer around one shared 33x33 multiplier,
// a registered vertex memory and an iterative CORDIC. Uses rbe_pkg,
// rbe_in_if and rbe_out_if.
//
// One request at a time. Add force, add torque and load vertex complete as
// they are accepted. Integrate runs multiply and update steps, three products
// per moving axis, then reports; place goes to the report at once. A report of
// the body position alone is one result. A polygon report runs angle range
// reduction (reciprocal multiply, back multiply, subtract, one correction), the
// fold and the CORDIC rotations, then for each vertex a memory read, four
// products through the shared multiplier and the hand-off. A result waits in
// the output register while the next request is taken.
module rigid_body_euler_integrator (
  input  logic        clk,
  input  logic        rst_n,
  rbe_in_if.sink      in_req,
  rbe_out_if.source   out_res,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_MUL    = 8'b0000_0010,
    S_APPLY  = 8'b0000_0100,
    S_MOD    = 8'b0000_1000,
    S_FOLD   = 8'b0001_0000,
    S_CORDIC = 8'b0010_0000,
    S_VREAD  = 8'b0100_0000,
    S_VMUL   = 8'b1000_0000
  } state_t;

  state_t state_r;
  logic   emit_r;

  // configuration registers
  logic [31:0] inv_mass_r, inv_inertia_r;
  logic [15:0] time_step_r;
  logic        is_polygon_r;
  logic [4:0]  vertex_count_r;

  // body state: index 0 x, 1 y, 2 angle
  logic signed [31:0] pos_r [3];
  logic signed [31:0] vel_r [3];
  logic signed [31:0] force_x_r, force_y_r, torque_r;

  // sequencing
  logic [1:0] axis_r, phase_r;
  logic [4:0] step_r;
  logic [2:0] mstep_r;
  logic [4:0] vidx_r;
  logic signed [31:0] acc_r;

  // angle reduction and CORDIC
  logic [45:0]        rem_r;
  logic               neg_r, flip_r;
  logic signed [33:0] cx_r, cy_r;
  logic signed [34:0] cz_r;
  logic signed [32:0] cos_r, sin_r;

  // multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_r;
  logic signed [66:0] sum_r;

  // vertex memory
  logic [63:0] vert_mem [rbe_pkg::MaxVertices];
  logic [63:0] rd_data_r;

  // pending result and output register
  logic signed [31:0] res_x_r, res_y_r;
  logic [3:0]         res_idx_r;
  logic               res_last_r;
  logic               out_valid_r;
  logic [3:0]         out_idx_r;
  logic signed [31:0] out_x_r, out_y_r, out_ang_r;
  logic               out_last_r;

  logic [4:0] n_vert;
  logic       poly_go;
  logic       in_fire;
  logic [1:0] axis_idx;
  logic signed [31:0] f_sel;
  logic [31:0]        inv_sel;
  logic signed [31:0] vx_rd, vy_rd;
  logic               emit_slot;

  assign n_vert  = (vertex_count_r > 5'(rbe_pkg::MaxVertices)) ?
                   5'(rbe_pkg::MaxVertices) : vertex_count_r;
  assign poly_go = is_polygon_r && (n_vert != 5'd0);
  assign in_req.ready = (state_r == S_IDLE) && !emit_r;
  assign in_fire  = in_req.valid && in_req.ready;
  assign axis_idx = axis_r;
  assign vx_rd    = rd_data_r[63:32];
  assign vy_rd    = rd_data_r[31:0];
  assign emit_slot = !out_valid_r || out_res.ready;

  // per-axis operand select
  always_comb begin
    case (axis_r)
      2'd0:    begin f_sel = force_x_r; inv_sel = inv_mass_r;    end
      2'd1:    begin f_sel = force_y_r; inv_sel = inv_mass_r;    end
      default: begin f_sel = torque_r;  inv_sel = inv_inertia_r; end
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = 33'sd0;
    mul_b = 33'sd0;
    if (state_r == S_MUL) begin
      case (phase_r)
        2'd0:    begin mul_a = 33'(f_sel); mul_b = $signed({1'b0, inv_sel}); end
        2'd1:    begin mul_a = 33'(acc_r); mul_b = $signed({17'd0, time_step_r}); end
        default: begin
          mul_a = 33'(vel_r[axis_idx]);
          mul_b = $signed({17'd0, time_step_r});
        end
      endcase
    end else if (state_r == S_MOD) begin
      // quotient estimate, then quotient times 2*pi as 4q times pi/2
      if (step_r == 5'd0) begin
        mul_a = $signed({1'b0, rem_r[45:14]});
        mul_b = $signed({1'b0, rbe_pkg::ModRecip});
      end else begin
        mul_a = $signed({16'd0, prod_r[63:49], 2'b00});
        mul_b = 33'(rbe_pkg::HalfPiQ30);
      end
    end else if (state_r == S_VMUL) begin
      case (mstep_r)
        3'd0:    begin mul_a = 33'(vx_rd); mul_b = cos_r; end
        3'd1:    begin mul_a = 33'(vy_rd); mul_b = sin_r; end
        3'd2:    begin mul_a = 33'(vx_rd); mul_b = sin_r; end
        default: begin mul_a = 33'(vy_rd); mul_b = cos_r; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // vertex memory: written by load requests, read through a register
  always_ff @(posedge clk) begin
    if (in_fire && in_req.op == rbe_pkg::OP_LOAD_VERT) begin
      vert_mem[in_req.vertex_index[rbe_pkg::VIdxW-1:0]] <=
        {in_req.value_x, in_req.value_y};
    end
    rd_data_r <= vert_mem[vidx_r[rbe_pkg::VIdxW-1:0]];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_mass_r     <= '0;
      inv_inertia_r  <= '0;
      time_step_r    <= rbe_pkg::TimeStepReset;
      is_polygon_r   <= 1'b0;
      vertex_count_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rbe_pkg::REG_INV_MASS:     inv_mass_r     <= cfg_wdata;
        rbe_pkg::REG_INV_INERTIA:  inv_inertia_r  <= cfg_wdata;
        rbe_pkg::REG_TIME_STEP:    time_step_r    <= cfg_wdata[15:0];
        rbe_pkg::REG_IS_POLYGON:   is_polygon_r   <= cfg_wdata[0];
        rbe_pkg::REG_VERTEX_COUNT: vertex_count_r <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_r && emit_slot) begin
      out_valid_r <= 1'b1;
      out_idx_r   <= res_idx_r;
      out_x_r     <= res_x_r;
      out_y_r     <= res_y_r;
      out_ang_r   <= pos_r[2];
      out_last_r  <= res_last_r;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.item_index = out_idx_r;
  assign out_res.world_x    = out_x_r;
  assign out_res.world_y    = out_y_r;
  assign out_res.body_angle = out_ang_r;
  assign out_res.last       = out_last_r;

  // main sequencer
  always_ff @(posedge clk) begin
    logic signed [67:0] t;
    logic signed [46:0] zs;
    logic signed [33:0] dx, dy;
    logic signed [66:0] s2;
    if (!rst_n) begin
      state_r   <= S_IDLE;
      emit_r    <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= '0;
        vel_r[i] <= '0;
      end
      force_x_r <= '0;
      force_y_r <= '0;
      torque_r  <= '0;
      axis_r    <= '0;
      phase_r   <= '0;
      step_r    <= '0;
      mstep_r   <= '0;
      vidx_r    <= '0;
    end else if (emit_r) begin
      // hand a result to the output register
      if (emit_slot) begin
        if (res_last_r) begin
          emit_r  <= 1'b0;
          state_r <= S_IDLE;
        end else begin
          emit_r  <= 1'b0;
          vidx_r  <= vidx_r + 5'd1;
          state_r <= S_VREAD;
        end
      end
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            case (in_req.op)
              rbe_pkg::OP_ADD_FORCE: begin
                force_x_r <= rbe_pkg::sat32(68'(force_x_r) + 68'(in_req.value_x));
                force_y_r <= rbe_pkg::sat32(68'(force_y_r) + 68'(in_req.value_y));
              end
              rbe_pkg::OP_ADD_TORQUE: begin
                torque_r <= rbe_pkg::sat32(68'(torque_r) + 68'(in_req.value_x));
              end
              rbe_pkg::OP_INTEGRATE: begin
                axis_r  <= 2'd0;
                phase_r <= 2'd0;
                state_r <= S_MUL;
              end
              rbe_pkg::OP_PLACE: begin
                pos_r[0] <= in_req.value_x;
                pos_r[1] <= in_req.value_y;
                pos_r[2] <= '0;
                for (int i = 0; i < 3; i++) vel_r[i] <= '0;
                force_x_r <= '0;
                force_y_r <= '0;
                torque_r  <= '0;
                if (poly_go) begin
                  rem_r   <= '0;
                  neg_r   <= 1'b0;
                  step_r  <= '0;
                  state_r <= S_MOD;
                end else begin
                  res_idx_r  <= 4'd0;
                  res_x_r    <= in_req.value_x;
                  res_y_r    <= in_req.value_y;
                  res_last_r <= 1'b1;
                  emit_r     <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end

        S_MUL: begin
          if (axis_r == 2'd3) begin
            // all axes done: clear sums and report
            force_x_r <= '0;
            force_y_r <= '0;
            torque_r  <= '0;
            if (poly_go) begin
              zs     = 47'(pos_r[2]) <<< (30 - rbe_pkg::FracBits);
              neg_r  <= zs[46];
              rem_r  <= zs[46] ? 46'(-zs) : zs[45:0];
              step_r <= '0;
              state_r <= S_MOD;
            end else begin
              res_idx_r  <= 4'd0;
              res_x_r    <= pos_r[0];
              res_y_r    <= pos_r[1];
              res_last_r <= 1'b1;
              emit_r     <= 1'b1;
              state_r    <= S_IDLE;
            end
          end else if (inv_sel == 32'd0) begin
            axis_r <= (axis_r == 2'd0) ? 2'd2 : axis_r + 2'd1;
          end else begin
            state_r <= S_APPLY;
          end
        end

        S_APPLY: begin
          t = 68'(prod_r);
          case (phase_r)
            2'd0: begin
              acc_r   <= rbe_pkg::sat32(t >>> rbe_pkg::FracBits);
              phase_r <= 2'd1;
            end
            2'd1: begin
              vel_r[axis_idx] <= rbe_pkg::sat32(68'(vel_r[axis_idx]) + (t >>> 16));
              phase_r <= 2'd2;
            end
            default: begin
              pos_r[axis_idx] <= rbe_pkg::sat32(68'(pos_r[axis_idx]) + (t >>> 16));
              phase_r <= 2'd0;
              axis_r  <= axis_r + 2'd1;
            end
          endcase
          state_r <= S_MUL;
        end

        S_MOD: begin
          // remainder modulo 2*pi: estimate falls short by at most one period
          if (step_r == 5'd2) rem_r <= rem_r - prod_r[45:0];
          if (step_r == 5'd3) begin
            if (rem_r >= 46'(rbe_pkg::TwoPiQ30)) rem_r <= rem_r - 46'(rbe_pkg::TwoPiQ30);
            state_r <= S_FOLD;
          end
          step_r <= step_r + 5'd1;
        end

        S_FOLD: begin
          // back into [-pi, pi], then into [-pi/2, pi/2]
          zs = neg_r ? -$signed({1'b0, rem_r}) : $signed({1'b0, rem_r});
          if (zs > rbe_pkg::PiQ30)  zs = zs - rbe_pkg::TwoPiQ30;
          if (zs < -rbe_pkg::PiQ30) zs = zs + rbe_pkg::TwoPiQ30;
          flip_r <= 1'b0;
          if (zs > rbe_pkg::HalfPiQ30) begin
            zs = zs - rbe_pkg::PiQ30;
            flip_r <= 1'b1;
          end else if (zs < -rbe_pkg::HalfPiQ30) begin
            zs = zs + rbe_pkg::PiQ30;
            flip_r <= 1'b1;
          end
          cz_r   <= zs[34:0];
          cx_r   <= rbe_pkg::CordicGain;
          cy_r   <= '0;
          step_r <= '0;
          state_r <= S_CORDIC;
        end

        S_CORDIC: begin
          dx = cy_r >>> step_r;
          dy = cx_r >>> step_r;
          if (!cz_r[34]) begin
            cx_r <= cx_r - dx;
            cy_r <= cy_r + dy;
            cz_r <= cz_r - rbe_pkg::atan_q30(step_r);
          end else begin
            cx_r <= cx_r + dx;
            cy_r <= cy_r - dy;
            cz_r <= cz_r + rbe_pkg::atan_q30(step_r);
          end
          if (step_r == 5'(rbe_pkg::CordicSteps - 1)) begin
            if (!cz_r[34]) begin
              cos_r <= flip_r ? -33'(cx_r - dx) : 33'(cx_r - dx);
              sin_r <= flip_r ? -33'(cy_r + dy) : 33'(cy_r + dy);
            end else begin
              cos_r <= flip_r ? -33'(cx_r + dx) : 33'(cx_r + dx);
              sin_r <= flip_r ? -33'(cy_r - dy) : 33'(cy_r - dy);
            end
            vidx_r  <= '0;
            state_r <= S_VREAD;
          end else begin
            step_r <= step_r + 5'd1;
          end
        end

        S_VREAD: begin
          mstep_r <= '0;
          state_r <= S_VMUL;
        end

        S_VMUL: begin
          // each product is registered and used at the next step
          case (mstep_r)
            3'd1: sum_r <= 67'(prod_r);
            3'd2: begin
              s2 = sum_r - 67'(prod_r);
              res_x_r <= rbe_pkg::sat32(68'(pos_r[0]) + 68'(s2 >>> 30));
            end
            3'd3: sum_r <= 67'(prod_r);
            3'd4: begin
              s2 = sum_r + 67'(prod_r);
              res_y_r    <= rbe_pkg::sat32(68'(pos_r[1]) + 68'(s2 >>> 30));
              res_idx_r  <= vidx_r[3:0];
              res_last_r <= (vidx_r + 5'd1 == n_vert);
              emit_r     <= 1'b1;
            end
            default: ;
          endcase
          if (mstep_r != 3'd4) mstep_r <= mstep_r + 3'd1;
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/tb_channels.sv =====
// testbench-side notes on the channel interfaces
// the interfaces themselves come from rtl/rbe_in_if.sv and rtl/rbe_out_if.sv
package tb_channels_pkg;
  timeunit 1ns;
  timeprecision 1ps;
  // one request as the driver queues it
  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] value_x;
    logic signed [31:0] value_y;
    logic [3:0]         vertex_index;
  } body_req_t;
  // one reported world point
  typedef struct packed {
    logic [3:0]         item_index;
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] body_angle;
    logic               last;
  } world_pt_t;
endpackage

// ===== tb/tb.sv =====
// top testbench for rigid_body_euler_integrator: drives requests, predicts
// world points in fixed point, and checks results; uses rbe_pkg, tb_channels_pkg
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_wdata;
  rbe_in_if  in_req ();
  rbe_out_if out_res ();

  rigid_body_euler_integrator u_top (
    .clk, .rst_n, .in_req(in_req.sink), .out_res(out_res.source),
    .cfg_we, .cfg_index, .cfg_wdata
  );

  // predictor state
  longint m_inv_mass, m_inv_inertia, m_dt, m_poly, m_nvert;
  longint px, py, vx, vy, hd, sr, fax, fay, tqa;
  longint vtx_x [16], vtx_y [16];

  tb_channels_pkg::body_req_t pending_reqs [$];
  tb_channels_pkg::world_pt_t expected_pts [$];
  int errors = 0;
  int send_idle_pct = 0, stall_pct = 0;
  int hold_cycles = 0;
  bit sending = 0;
  bit in_taken = 0;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint angle_q30(int i);
    case (i)
      0: return 843314856;
      1: return 497837829;
      2: return 263043836;
      3: return 133525158;
      4: return 67021686;
      5: return 33543515;
      6: return 16775850;
      7: return 8388437;
      8: return 4194282;
      9: return 2097149;
      default: return 64'sd1 <<< (30 - i);
    endcase
  endfunction

  // cordic sine and cosine of a q16.16 angle, results in q2.30
  task automatic sine_cosine(input longint ang, output longint s, output longint c);
    longint z, x, y, dx, dy;
    bit flip;
    z = ang * (64'sd1 <<< 14);
    x = 652032874; y = 0; flip = 0;
    z = z % 64'sd6746518852;
    if (z > 64'sd3373259426) z -= 64'sd6746518852;
    if (z < -64'sd3373259426) z += 64'sd6746518852;
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426; flip = 1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426; flip = 1;
    end
    for (int i = 0; i < 30; i++) begin
      dx = fshr(y, i); dy = fshr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= angle_q30(i);
      end else begin
        x += dx; y -= dy; z += angle_q30(i);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  // queue the world points of one report
  task automatic predict_report();
    longint n, s, c, rx, ry;
    tb_channels_pkg::world_pt_t p;
    n = m_nvert > 16 ? 16 : m_nvert;
    if (!m_poly || n == 0) begin
      p = '{4'd0, px[31:0], py[31:0], hd[31:0], 1'b1};
      expected_pts.insert(expected_pts.size(), p);
    end else begin
      sine_cosine(hd, s, c);
      for (int i = 0; i < n; i++) begin
        rx = fshr(vtx_x[i] * c - vtx_y[i] * s, 30);
        ry = fshr(vtx_x[i] * s + vtx_y[i] * c, 30);
        rx = clamp32(px + rx); ry = clamp32(py + ry);
        p = '{i[3:0], rx[31:0], ry[31:0], hd[31:0], i == n - 1};
        expected_pts.insert(expected_pts.size(), p);
      end
    end
  endtask

  task automatic step_axis(input longint f, input longint inv, inout longint v,
                           inout longint p);
    longint a;
    a = clamp32(fshr(f * inv, rbe_pkg::FracBits));
    v = clamp32(v + fshr(a * m_dt, 16));
    p = clamp32(p + fshr(v * m_dt, 16));
  endtask

  // apply one accepted request to the body model
  task automatic predict_body(input tb_channels_pkg::body_req_t r);
    longint a, b;
    a = longint'(r.value_x); b = longint'(r.value_y);
    case (r.op)
      rbe_pkg::OP_ADD_FORCE: begin
        fax = clamp32(fax + a); fay = clamp32(fay + b);
      end
      rbe_pkg::OP_ADD_TORQUE: tqa = clamp32(tqa + a);
      rbe_pkg::OP_INTEGRATE: begin
        if (m_inv_mass != 0) begin
          step_axis(fax, m_inv_mass, vx, px);
          step_axis(fay, m_inv_mass, vy, py);
        end
        if (m_inv_inertia != 0) step_axis(tqa, m_inv_inertia, sr, hd);
        fax = 0; fay = 0; tqa = 0;
        predict_report();
      end
      rbe_pkg::OP_LOAD_VERT: begin
        vtx_x[r.vertex_index] = a; vtx_y[r.vertex_index] = b;
      end
      rbe_pkg::OP_PLACE: begin
        px = a; py = b; vx = 0; vy = 0; hd = 0; sr = 0;
        fax = 0; fay = 0; tqa = 0;
        predict_report();
      end
      default: ;
    endcase
  endtask

  // request driver, changes at falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_req.valid <= 0;
    end else if (in_req.valid && !in_taken) begin
      // hold current request until it is taken
    end else if (sending && pending_reqs.size() > 0 &&
                 $urandom_range(99) >= send_idle_pct) begin
      tb_channels_pkg::body_req_t r;
      in_taken = 1'b0;
      r = pending_reqs.pop_front();
      in_req.valid <= 1;
      in_req.op <= r.op;
      in_req.value_x <= r.value_x;
      in_req.value_y <= r.value_y;
      in_req.vertex_index <= r.vertex_index;
    end else begin
      in_taken = 1'b0;
      in_req.valid <= 0;
    end
  end

  // result ready, with a long hold-off when asked
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_res.ready <= 0;
    end else begin
      out_res.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // monitor: accepted requests feed the predictor, results are checked
  always @(posedge clk) begin
    if (rst_n && in_req.valid && in_req.ready) begin
      in_taken = 1'b1;
      predict_body('{in_req.op, in_req.value_x, in_req.value_y, in_req.vertex_index});
    end
    if (rst_n && out_res.valid && out_res.ready) begin
      if (expected_pts.size() == 0) begin
        $error("unexpected result index %0d", out_res.item_index);
        errors++;
      end else begin
        tb_channels_pkg::world_pt_t e;
        e = expected_pts.pop_front();
        if (out_res.item_index !== e.item_index) begin
          $error("item_index exp %0d got %0d", e.item_index, out_res.item_index);
          errors++;
        end
        if (out_res.world_x !== e.world_x) begin
          $error("world_x exp %0d got %0d", e.world_x, out_res.world_x);
          errors++;
        end
        if (out_res.world_y !== e.world_y) begin
          $error("world_y exp %0d got %0d", e.world_y, out_res.world_y);
          errors++;
        end
        if (out_res.body_angle !== e.body_angle) begin
          $error("body_angle exp %0d got %0d", e.body_angle, out_res.body_angle);
          errors++;
        end
        if (out_res.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, out_res.last);
          errors++;
        end
      end
    end
  end

  task automatic add_req(input logic [2:0] op, input logic [31:0] a,
                         input logic [31:0] b, input logic [3:0] vi);
    tb_channels_pkg::body_req_t r;
    r = '{op, a, b, vi};
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  // wait for the queue to drain and the block to go quiet
  task automatic drain();
    while (pending_reqs.size() > 0 || in_req.valid || expected_pts.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] d);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= d;
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      rbe_pkg::REG_INV_MASS: m_inv_mass = longint'(d);
      rbe_pkg::REG_INV_INERTIA: m_inv_inertia = longint'(d);
      rbe_pkg::REG_TIME_STEP: m_dt = longint'(d[15:0]);
      rbe_pkg::REG_IS_POLYGON: m_poly = longint'(d[0]);
      rbe_pkg::REG_VERTEX_COUNT: m_nvert = longint'(d[4:0]);
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rnd_value();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(20'hfffff) - 20'h80000;
      default: return $urandom;
    endcase
  endfunction

  // a random mix of forces, torque, integrate, place, vertex loads and unused op codes
  task automatic random_block(input int n);
    for (int k = 0; k < n; k++) begin
      int pick;
      pick = $urandom_range(99);
      if (pick < 35)
        add_req(rbe_pkg::OP_ADD_FORCE, rnd_value(), rnd_value(), 4'($urandom));
      else if (pick < 55)
        add_req(rbe_pkg::OP_ADD_TORQUE, rnd_value(), $urandom, 4'($urandom));
      else if (pick < 85)
        add_req(rbe_pkg::OP_INTEGRATE, $urandom, $urandom, 4'($urandom));
      else if (pick < 93)
        add_req(rbe_pkg::OP_PLACE, rnd_value(), rnd_value(), 4'($urandom));
      else if (pick < 97)
        add_req(rbe_pkg::OP_LOAD_VERT, rnd_value(), rnd_value(), 4'($urandom));
      else
        add_req(3'(5 + $urandom_range(2)), $urandom, $urandom, 4'($urandom));
    end
  endtask

  task automatic set_body(input logic [31:0] im, input logic [31:0] ii,
                          input logic [15:0] dt, input bit poly, input logic [4:0] nv);
    write_reg(rbe_pkg::REG_INV_MASS, im);
    write_reg(rbe_pkg::REG_INV_INERTIA, ii);
    write_reg(rbe_pkg::REG_TIME_STEP, {16'd0, dt});
    write_reg(rbe_pkg::REG_IS_POLYGON, {31'd0, poly});
    write_reg(rbe_pkg::REG_VERTEX_COUNT, {27'd0, nv});
  endtask

  initial begin
    rst_n = 0; cfg_we = 0; cfg_index = rbe_pkg::REG_INV_MASS; cfg_wdata = 0;
    in_req.valid = 0; in_req.op = rbe_pkg::OP_ADD_FORCE; in_req.value_x = 0;
    in_req.value_y = 0; in_req.vertex_index = 0; out_res.ready = 0;
    m_inv_mass = 0; m_inv_inertia = 0; m_dt = longint'(rbe_pkg::TimeStepReset);
    m_poly = 0; m_nvert = 0;
    {px, py, vx, vy, hd, sr, fax, fay, tqa} = '0;
    foreach (vtx_x[i]) begin
      vtx_x[i] = 0; vtx_y[i] = 0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    sending = 1;

    // directed: reset config, then extremes with all 16 vertices loaded
    add_req(rbe_pkg::OP_INTEGRATE, 0, 0, 0);
    add_req(rbe_pkg::OP_PLACE, 32'h7fffffff, 32'h80000000, 0);
    add_req(3'd5, 1, 2, 3);
    add_req(3'd7, 1, 2, 3);
    drain();
    for (int i = 0; i < 16; i++)
      add_req(rbe_pkg::OP_LOAD_VERT,
              (i[0] ? 32'h80000000 : 32'h7fffffff) ^ $urandom_range(255),
              (i[1] ? 32'h7fffffff : 32'h80000000) ^ $urandom_range(255), i[3:0]);
    drain();
    set_body(32'hffffffff, 32'hffffffff, 16'hffff, 1, 5'd16);
    add_req(rbe_pkg::OP_ADD_FORCE, 32'h7fffffff, 32'h80000000, 0);
    add_req(rbe_pkg::OP_ADD_FORCE, 32'h7fffffff, 32'h80000000, 0);
    add_req(rbe_pkg::OP_ADD_TORQUE, 32'h00030000, 0, 0);
    add_req(rbe_pkg::OP_INTEGRATE, 0, 0, 0);
    add_req(rbe_pkg::OP_PLACE, 32'h00010000, 32'hffff0000, 0);
    drain();
    set_body(0, 32'h00010000, 16'd0, 1, 5'd31);
    add_req(rbe_pkg::OP_ADD_TORQUE, 32'h80000000, 0, 0);
    add_req(rbe_pkg::OP_INTEGRATE, 0, 0, 0);
    drain();
    set_body(32'h00010000, 32'h00010000, 16'h4000, 1, 5'd0);
    add_req(rbe_pkg::OP_INTEGRATE, 0, 0, 0);
    drain();

    // random phases with varied settings and idling
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 81 : 24) : 0;
      stall_pct = (ph == 2) ? 81 : (ph == 3 ? 24 : 0);
      set_body($urandom_range(32'h00040000), $urandom_range(32'h00040000),
               16'($urandom), ph != 1, 5'($urandom_range(1, 6)));
      if (ph == 0) hold_cycles = 600;
      random_block(21);
      drain();
    end
    send_idle_pct = 0; stall_pct = 0;

    while (expected_pts.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule
